### hdl/ckt_pkg.sv
`default_nettype none

package ckt_pkg;

    // Input operation codes.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_REPLY  = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_SYNC   = 3'd4;

    // Result kinds.
    localparam logic [3:0] KIND_HEARTBEAT = 4'd0;
    localparam logic [3:0] KIND_TIMEOUT   = 4'd1;
    localparam logic [3:0] KIND_ADDED     = 4'd2;
    localparam logic [3:0] KIND_DUPLICATE = 4'd3;
    localparam logic [3:0] KIND_FULL      = 4'd4;
    localparam logic [3:0] KIND_REMOVED   = 4'd5;
    localparam logic [3:0] KIND_NOT_FOUND = 4'd6;
    localparam logic [3:0] KIND_REPLY_OK  = 4'd7;
    localparam logic [3:0] KIND_REPLY_IGN = 4'd8;
    localparam logic [3:0] KIND_SYNC      = 4'd9;
    localparam logic [3:0] KIND_TICK_DONE = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_INTERVAL    = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_TIMEOUT     = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] INTERVAL_RESET    = 16'd1000;
    localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd5;
    localparam logic [31:0] TIMEOUT_RESET     = 32'd10000;

    localparam logic [3:0] TRIES_MAX = 4'd15;

    typedef struct packed {
        logic [15:0] interval;
        logic [3:0]  retry_limit;
        logic [31:0] timeout;
    } ckt_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [15:0] port;
        logic [15:0] id;
        logic [31:0] last_heard;
        logic [31:0] probe_sent;
        logic        waiting;
        logic [3:0]  tries;
    } peer_entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_CLEAR,
        CELL_REPLY,
        CELL_PROBE
    } cell_op_t;

endpackage

`default_nettype wire

### hdl/ckt_cell.sv
`default_nettype none

module ckt_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ckt_pkg::cell_op_t     op,
    input  ckt_pkg::peer_entry_t  new_entry,
    input  ckt_pkg::peer_entry_t  left_entry,
    input  ckt_pkg::peer_entry_t  right_entry,
    input  wire [31:0]            clock_ms,
    input  ckt_pkg::ckt_cfg_t     cfg,
    output ckt_pkg::peer_entry_t  entry,
    output logic                  drop,
    output logic                  probe
);
    import ckt_pkg::*;

    logic        valid_reg, valid_next;
    peer_entry_t data_reg, data_next;
    logic [31:0] elapsed;
    logic [20:0] retry_due;

    // The stored peer, with the valid bit taken from its reset flop.
    always_comb
    begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

    // Timeout and heartbeat decisions against the current clock.
    always_comb
    begin
        elapsed   = clock_ms - data_reg.last_heard;
        retry_due = 21'(cfg.interval) * 21'({1'b0, data_reg.tries} + 5'd1);
        drop      = (elapsed >= 32'(cfg.interval)) &&
                    ((elapsed >= cfg.timeout) || (data_reg.tries >= cfg.retry_limit));
        probe     = !data_reg.waiting || (elapsed >= 32'(retry_due));
    end

    // Next contents: load, shift from a neighbor, or update in place.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (op)
            CELL_LOAD_NEW:
            begin
                valid_next = 1'b1;
                data_next  = new_entry;
            end
            CELL_FROM_LEFT:
            begin
                valid_next = left_entry.valid;
                data_next  = left_entry;
            end
            CELL_FROM_RIGHT:
            begin
                valid_next = right_entry.valid;
                data_next  = right_entry;
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            CELL_REPLY:
            begin
                data_next.last_heard = clock_ms;
                data_next.waiting    = 1'b0;
                data_next.tries      = 4'd0;
            end
            CELL_PROBE:
            begin
                if (data_reg.tries == 4'd0)
                begin
                    data_next.probe_sent = clock_ms;
                end
                data_next.waiting = 1'b1;
                if (data_reg.tries != TRIES_MAX)
                begin
                    data_next.tries = data_reg.tries + 4'd1;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### hdl/client_keepalive_table.sv
`default_nettype none

// Keep-alive table for up to MAX_PEERS peers, held in a row of cells kept in
// ascending id order (free cells may sit anywhere in the row). Reply, add,
// remove and sync each give one result. A tick advances the clock, then
// steps through every cell, one cell per cycle while the output is not
// stalled, and ends with a tick-done transfer. A new input is taken only
// once the previous input's work is finished.
module client_keepalive_table #(
    parameter int MAX_PEERS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_write,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [2:0]  opcode,
    input  wire  [15:0] delta_ms,
    input  wire  [31:0] peer_address,
    input  wire  [15:0] peer_port,
    input  wire  [15:0] peer_id,
    input  wire signed [31:0] peer_clock,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [3:0]  kind,
    output logic [15:0] out_peer_id,
    output logic [31:0] out_address,
    output logic [15:0] out_port,
    output logic [31:0] time_value,
    output logic signed [31:0] echo_clock,
    output logic        last
);
    import ckt_pkg::*;

    localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   walk_idx_reg;
    logic [31:0]        clock_reg;
    logic [15:0]        next_id_reg;
    ckt_cfg_t           cfg_reg;
    logic               out_valid_reg;
    logic [3:0]         kind_reg;
    logic [15:0]        id_reg;
    logic [31:0]        address_reg;
    logic [15:0]        port_reg;
    logic [31:0]        time_reg;
    logic [31:0]        echo_reg;
    logic               last_reg;

    peer_entry_t        cell_entry [MAX_PEERS];
    cell_op_t           cell_op    [MAX_PEERS];
    logic               cell_drop  [MAX_PEERS];
    logic               cell_probe [MAX_PEERS];
    peer_entry_t        new_entry;

    logic [MAX_PEERS-1:0] valid_vec;
    logic [MAX_PEERS-1:0] match_addr;
    logic [MAX_PEERS-1:0] match_id;
    logic [MAX_PEERS-1:0] id_taken;
    logic [MAX_PEERS-1:0] at_or_after;
    logic [MAX_PEERS-1:0] insert_cell;
    logic [MAX_PEERS-1:0] right_zone;
    logic [MAX_PEERS-1:0] left_zone;
    logic [MAX_PEERS-1:0] left_load;
    logic                 hole_right;
    peer_entry_t          addr_hit;
    peer_entry_t          id_hit;
    peer_entry_t          walk_entry;
    logic                 walk_drop;
    logic                 walk_probe;
    logic                 in_accept;
    logic                 slot_free;
    logic                 do_insert;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign out_peer_id = id_reg;
    assign out_address = address_reg;
    assign out_port    = port_reg;
    assign time_value  = time_reg;
    assign echo_clock  = echo_reg;
    assign last        = last_reg;

    always_comb
    begin
        new_entry.valid      = 1'b1;
        new_entry.address    = peer_address;
        new_entry.port       = peer_port;
        new_entry.id         = next_id_reg;
        new_entry.last_heard = clock_reg;
        new_entry.probe_sent = clock_reg;
        new_entry.waiting    = 1'b0;
        new_entry.tries      = 4'd0;
    end

    // The row of cells; each shifts from its left or right neighbor on insert.
    for (genvar g = 0; g < MAX_PEERS; g++)
    begin : g_cell
        peer_entry_t left_in;
        peer_entry_t right_in;
        if (g == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_entry[g-1];
        end
        if (g == MAX_PEERS - 1)
        begin : g_end
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_entry[g+1];
        end
        ckt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (cell_op[g]),
            .new_entry   (new_entry),
            .left_entry  (left_in),
            .right_entry (right_in),
            .clock_ms    (clock_reg),
            .cfg         (cfg_reg),
            .entry       (cell_entry[g]),
            .drop        (cell_drop[g]),
            .probe       (cell_probe[g])
        );
    end

    // Lookups by address and port, by id, and of the next id.
    always_comb
    begin
        addr_hit = '0;
        id_hit   = '0;
        for (int i = 0; i < MAX_PEERS; i++)
        begin
            valid_vec[i]  = cell_entry[i].valid;
            match_addr[i] = cell_entry[i].valid && (cell_entry[i].address == peer_address) &&
                            (cell_entry[i].port == peer_port);
            match_id[i]   = cell_entry[i].valid && (cell_entry[i].id == peer_id);
            id_taken[i]   = cell_entry[i].valid && (cell_entry[i].id == next_id_reg);
            if (match_addr[i])
            begin
                addr_hit = addr_hit | cell_entry[i];
            end
            if (match_id[i])
            begin
                id_hit = id_hit | cell_entry[i];
            end
        end
    end

    // Sorted insert: find the first larger id, then the nearest free cell.
    always_comb
    begin
        logic seen;
        logic blocked;
        logic lblocked;
        seen     = 1'b0;
        blocked  = 1'b0;
        lblocked = 1'b0;
        for (int i = 0; i < MAX_PEERS; i++)
        begin
            insert_cell[i] = !seen && cell_entry[i].valid && (cell_entry[i].id > next_id_reg);
            seen           = seen || insert_cell[i];
            at_or_after[i] = seen;
            right_zone[i]  = at_or_after[i] && !blocked;
            if (at_or_after[i] && !cell_entry[i].valid)
            begin
                blocked = 1'b1;
            end
        end
        hole_right = |(at_or_after & ~valid_vec);
        for (int i = MAX_PEERS - 1; i >= 0; i--)
        begin
            left_zone[i] = !at_or_after[i] && !lblocked;
            if (!at_or_after[i] && !cell_entry[i].valid)
            begin
                lblocked = 1'b1;
            end
            left_load[i] = !at_or_after[i] &&
                           ((i == MAX_PEERS - 1) ? 1'b1 : at_or_after[(i + 1) % MAX_PEERS]);
        end
    end

    assign do_insert = in_accept && (opcode == OP_ADD) && !(|match_addr) &&
                       !(&valid_vec) && !(|id_taken);

    assign walk_entry = cell_entry[walk_idx_reg];
    assign walk_drop  = cell_drop[walk_idx_reg];
    assign walk_probe = cell_probe[walk_idx_reg];

    // Commands to the cells.
    always_comb
    begin
        for (int i = 0; i < MAX_PEERS; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (do_insert)
            begin
                if (hole_right)
                begin
                    if (insert_cell[i])
                    begin
                        cell_op[i] = CELL_LOAD_NEW;
                    end
                    else if (right_zone[i])
                    begin
                        cell_op[i] = CELL_FROM_LEFT;
                    end
                end
                else
                begin
                    if (left_load[i])
                    begin
                        cell_op[i] = CELL_LOAD_NEW;
                    end
                    else if (left_zone[i])
                    begin
                        cell_op[i] = CELL_FROM_RIGHT;
                    end
                end
            end
            else if (in_accept && (opcode == OP_REPLY) && match_addr[i] &&
                     cell_entry[i].waiting)
            begin
                cell_op[i] = CELL_REPLY;
            end
            else if (in_accept && (opcode == OP_REMOVE) && match_id[i])
            begin
                cell_op[i] = CELL_CLEAR;
            end
            else if ((state_reg == ST_WALK) && slot_free &&
                     (walk_idx_reg == IDX_W'(i)) && cell_entry[i].valid)
            begin
                if (cell_drop[i])
                begin
                    cell_op[i] = CELL_CLEAR;
                end
                else if (cell_probe[i])
                begin
                    cell_op[i] = CELL_PROBE;
                end
            end
        end
    end

    // Control, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            walk_idx_reg        <= '0;
            clock_reg           <= '0;
            next_id_reg         <= '0;
            cfg_reg.interval    <= INTERVAL_RESET;
            cfg_reg.retry_limit <= RETRY_LIMIT_RESET;
            cfg_reg.timeout     <= TIMEOUT_RESET;
            out_valid_reg       <= 1'b0;
            kind_reg            <= KIND_HEARTBEAT;
            id_reg              <= 16'd0;
            address_reg         <= 32'd0;
            port_reg            <= 16'd0;
            time_reg            <= 32'd0;
            echo_reg            <= 32'd0;
            last_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INTERVAL:    cfg_reg.interval    <= cfg_data[15:0];
                    REG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_data[3:0];
                    REG_TIMEOUT:     cfg_reg.timeout     <= cfg_data;
                    default:         cfg_reg.timeout     <= cfg_reg.timeout;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        id_reg      <= 16'd0;
                        address_reg <= peer_address;
                        port_reg    <= peer_port;
                        time_reg    <= 32'd0;
                        echo_reg    <= 32'd0;
                        last_reg    <= 1'b1;
                        case (opcode)
                            OP_TICK:
                            begin
                                clock_reg    <= clock_reg + 32'(delta_ms);
                                walk_idx_reg <= '0;
                                state_reg    <= ST_WALK;
                            end
                            OP_REPLY:
                            begin
                                out_valid_reg <= 1'b1;
                                id_reg        <= addr_hit.id;
                                if (|match_addr && addr_hit.waiting)
                                begin
                                    kind_reg <= KIND_REPLY_OK;
                                    time_reg <= clock_reg - addr_hit.probe_sent;
                                end
                                else
                                begin
                                    kind_reg <= KIND_REPLY_IGN;
                                end
                            end
                            OP_ADD:
                            begin
                                out_valid_reg <= 1'b1;
                                if (|match_addr)
                                begin
                                    kind_reg <= KIND_DUPLICATE;
                                    id_reg   <= addr_hit.id;
                                end
                                else if (&valid_vec)
                                begin
                                    kind_reg <= KIND_FULL;
                                end
                                else
                                begin
                                    kind_reg    <= (|id_taken) ? KIND_DUPLICATE : KIND_ADDED;
                                    id_reg      <= next_id_reg;
                                    next_id_reg <= next_id_reg + 16'd1;
                                end
                            end
                            OP_REMOVE:
                            begin
                                out_valid_reg <= 1'b1;
                                id_reg        <= peer_id;
                                address_reg   <= id_hit.address;
                                port_reg      <= id_hit.port;
                                kind_reg      <= (|match_id) ? KIND_REMOVED : KIND_NOT_FOUND;
                            end
                            OP_SYNC:
                            begin
                                out_valid_reg <= 1'b1;
                                kind_reg      <= KIND_SYNC;
                                time_reg      <= clock_reg;
                                echo_reg      <= peer_clock;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (slot_free)
                    begin
                        if (walk_entry.valid && (walk_drop || walk_probe))
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= walk_drop ? KIND_TIMEOUT : KIND_HEARTBEAT;
                            id_reg        <= walk_entry.id;
                            address_reg   <= walk_entry.address;
                            port_reg      <= walk_entry.port;
                            time_reg      <= walk_drop ? 32'd0 : clock_reg;
                            echo_reg      <= 32'd0;
                            last_reg      <= 1'b0;
                        end
                        if (walk_idx_reg == IDX_W'(MAX_PEERS - 1))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            walk_idx_reg <= walk_idx_reg + IDX_W'(1);
                        end
                    end
                end
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_TICK_DONE;
                        id_reg        <= 16'd0;
                        address_reg   <= 32'd0;
                        port_reg      <= 16'd0;
                        time_reg      <= clock_reg;
                        echo_reg      <= 32'd0;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // No new input while a tick walk is in progress.
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken during a tick walk");

    // A peer address and port appears in at most one cell.
    a_addr_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_addr))
        else $error("duplicate peer address in table");

    // Peer ids are unique among valid cells.
    a_id_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_id))
        else $error("duplicate peer id in table");

    // An accepted tick starts its walk at the first cell.
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (opcode == OP_TICK)) |=> ((state_reg == ST_WALK) && (walk_idx_reg == '0)))
        else $error("tick walk did not start");

endmodule

`default_nettype wire
